>>> src/bale_pkg.sv
// Shared types and codes for the bounded array list engine.
// Holds request and result records, operation and status codes.
// No dependencies.
package bale_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned PosW    = 5;
  localparam int unsigned StatW   = 2;
  localparam int unsigned FidxW   = 4;
  localparam int unsigned CountW  = 5;

  localparam logic [OpW-1:0] OP_INSERT   = 3'd0;
  localparam logic [OpW-1:0] OP_DELETE   = 3'd1;
  localparam logic [OpW-1:0] OP_LOCATE   = 3'd2;
  localparam logic [OpW-1:0] OP_RETRIEVE = 3'd3;
  localparam logic [OpW-1:0] OP_SORTED   = 3'd4;

  localparam logic [StatW-1:0] STAT_OK      = 2'd0;
  localparam logic [StatW-1:0] STAT_BADPOS  = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL    = 2'd2;
  localparam logic [StatW-1:0] STAT_MISSING = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]          op;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]        status;
    logic [FidxW-1:0]        found_index;
    logic signed [DataW-1:0] read_value;
    logic [CountW-1:0]       entry_count;
  } res_t;

endpackage

>>> src/bale_mem.sv
// Entry store for the list engine: one write port, one read port,
// registered read data. Depends on bale_pkg for the data width.
module bale_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AW-1:0]                    waddr_i,
  input  logic signed [bale_pkg::DataW-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [AW-1:0]                    raddr_i,
  output logic signed [bale_pkg::DataW-1:0] rdata_o
);

  logic signed [bale_pkg::DataW-1:0] mem_q [DEPTH];
  logic signed [bale_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bale_ctrl.sv
// Sequencer for the list engine: checks each request, then walks the
// entry memory one entry per cycle through a single compare unit.
// Depends on bale_pkg and drives bale_mem.
module bale_ctrl #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned CW       = $clog2(CAPACITY + 1),
  parameter int unsigned AW       = $clog2(CAPACITY)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  bale_pkg::req_t                    req_i,
  output logic                              idle_o,
  output logic                              done_o,
  input  logic                              res_ready_i,
  output bale_pkg::res_t                    res_o,
  output logic                              mem_we_o,
  output logic [AW-1:0]                     mem_waddr_o,
  output logic signed [bale_pkg::DataW-1:0] mem_wdata_o,
  output logic                              mem_re_o,
  output logic [AW-1:0]                     mem_raddr_o,
  input  logic signed [bale_pkg::DataW-1:0] mem_rdata_i
);

  localparam int unsigned XW = CW + bale_pkg::PosW;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_RD   = 4'd1;
  localparam logic [3:0] S_INS_SH   = 4'd2;
  localparam logic [3:0] S_SRT_RD   = 4'd3;
  localparam logic [3:0] S_SRT_CMP  = 4'd4;
  localparam logic [3:0] S_PLACE    = 4'd5;
  localparam logic [3:0] S_DEL_RD   = 4'd6;
  localparam logic [3:0] S_DEL_SH   = 4'd7;
  localparam logic [3:0] S_LOC_RD   = 4'd8;
  localparam logic [3:0] S_LOC_CMP  = 4'd9;
  localparam logic [3:0] S_RET_WAIT = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [bale_pkg::PosW-1:0]         pos_q, pos_d;
  logic signed [bale_pkg::DataW-1:0] value_q, value_d;
  logic [bale_pkg::StatW-1:0]        stat_q, stat_d;
  logic [bale_pkg::FidxW-1:0]        fidx_q, fidx_d;
  logic signed [bale_pkg::DataW-1:0] rval_q, rval_d;

  logic [CW-1:0] ptr_dec, ptr_dec2, ptr_inc, ptr_inc2, pos_c;
  logic [XW-1:0] pos_x, cnt_x;
  logic [CW+bale_pkg::FidxW-1:0]  fidx_x;
  logic [CW+bale_pkg::CountW-1:0] cnt_out_x;
  logic          full;
  logic          gt, eq;

  assign ptr_dec  = ptr_q - 1'b1;
  assign ptr_dec2 = ptr_q - 2'd2;
  assign ptr_inc  = ptr_q + 1'b1;
  assign ptr_inc2 = ptr_q + 2'd2;
  assign pos_c    = CW'(pos_q);
  assign pos_x    = XW'(req_i.position);
  assign cnt_x    = XW'(count_q);
  assign full     = (count_q == CW'(CAPACITY));
  assign fidx_x   = {{bale_pkg::FidxW{1'b0}}, ptr_q};
  assign cnt_out_x = {{bale_pkg::CountW{1'b0}}, count_q};

  // The one compare unit: stored entry against the request value.
  assign gt = (mem_rdata_i > value_q);
  assign eq = (mem_rdata_i == value_q);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    pos_d       = pos_q;
    value_d     = value_q;
    stat_d      = stat_q;
    fidx_d      = fidx_q;
    rval_d      = rval_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q[AW-1:0];
    mem_wdata_o = value_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_dec[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          pos_d   = req_i.position;
          value_d = req_i.value;
          stat_d  = bale_pkg::STAT_OK;
          fidx_d  = '0;
          rval_d  = '0;
          state_d = S_DONE;
          unique case (req_i.op)
            bale_pkg::OP_INSERT: begin
              if (pos_x > cnt_x) begin
                stat_d = bale_pkg::STAT_BADPOS;
              end else if (full) begin
                stat_d = bale_pkg::STAT_FULL;
              end else begin
                ptr_d   = count_q;
                state_d = S_INS_RD;
              end
            end
            bale_pkg::OP_DELETE: begin
              if (pos_x >= cnt_x) begin
                stat_d = bale_pkg::STAT_BADPOS;
              end else begin
                ptr_d   = CW'(req_i.position);
                state_d = S_DEL_RD;
              end
            end
            bale_pkg::OP_LOCATE: begin
              ptr_d   = '0;
              state_d = S_LOC_RD;
            end
            bale_pkg::OP_RETRIEVE: begin
              if (pos_x >= cnt_x) begin
                stat_d = bale_pkg::STAT_BADPOS;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AW'(req_i.position);
                state_d     = S_RET_WAIT;
              end
            end
            bale_pkg::OP_SORTED: begin
              if (full) begin
                stat_d = bale_pkg::STAT_FULL;
              end else begin
                ptr_d   = count_q;
                state_d = S_SRT_RD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_INS_RD: begin
        if (ptr_q == pos_c) begin
          state_d = S_PLACE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_dec[AW-1:0];
          state_d     = S_INS_SH;
        end
      end

      S_INS_SH: begin
        // move the entry below up one slot, fetch the next one meanwhile
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q[AW-1:0];
        mem_wdata_o = mem_rdata_i;
        ptr_d       = ptr_dec;
        if (ptr_dec != pos_c) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_dec2[AW-1:0];
        end else begin
          state_d = S_PLACE;
        end
      end

      S_SRT_RD: begin
        if (ptr_q == '0) begin
          state_d = S_PLACE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_dec[AW-1:0];
          state_d     = S_SRT_CMP;
        end
      end

      S_SRT_CMP: begin
        if (gt) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = ptr_q[AW-1:0];
          mem_wdata_o = mem_rdata_i;
          ptr_d       = ptr_dec;
          if (ptr_dec != '0) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = ptr_dec2[AW-1:0];
          end else begin
            state_d = S_PLACE;
          end
        end else begin
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q[AW-1:0];
        mem_wdata_o = value_q;
        count_d     = count_q + 1'b1;
        state_d     = S_DONE;
      end

      S_DEL_RD: begin
        if (ptr_inc < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_inc[AW-1:0];
          state_d     = S_DEL_SH;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end

      S_DEL_SH: begin
        // move the entry above down one slot
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q[AW-1:0];
        mem_wdata_o = mem_rdata_i;
        ptr_d       = ptr_inc;
        if (ptr_inc2 < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_inc2[AW-1:0];
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end

      S_LOC_RD: begin
        if (ptr_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_q[AW-1:0];
          state_d     = S_LOC_CMP;
        end else begin
          stat_d  = bale_pkg::STAT_MISSING;
          state_d = S_DONE;
        end
      end

      S_LOC_CMP: begin
        if (eq) begin
          fidx_d  = fidx_x[bale_pkg::FidxW-1:0];
          state_d = S_DONE;
        end else begin
          ptr_d = ptr_inc;
          if (ptr_inc < count_q) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = ptr_inc[AW-1:0];
          end else begin
            stat_d  = bale_pkg::STAT_MISSING;
            state_d = S_DONE;
          end
        end
      end

      S_RET_WAIT: begin
        rval_d  = mem_rdata_i;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    pos_q   <= pos_d;
    value_q <= value_d;
    stat_q  <= stat_d;
    fidx_q  <= fidx_d;
    rval_q  <= rval_d;
  end

  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_DONE);

  always_comb begin
    res_o.status      = stat_q;
    res_o.found_index = fidx_q;
    res_o.read_value  = rval_q;
    res_o.entry_count = cnt_out_x[bale_pkg::CountW-1:0];
  end

endmodule

>>> src/bounded_array_list_engine.sv
// Bounded array list engine: ordered list of signed 32-bit entries with
// insert, delete, locate, retrieve and sorted insert requests.
// Depends on bale_pkg, bale_ctrl and bale_mem.
//
// Usage:
//   Requests enter on the s_axis channel (op in tuser, value and position
//   in tdata); each request yields exactly one result on the m_axis channel
//   (status in tuser, found index, read value and entry count in tdata).
//   One request is worked on at a time. A rejected or unknown request goes
//   straight to the done state; retrieve waits for one registered read;
//   insert, delete, sorted insert and locate walk the entry memory one
//   entry per cycle, sorted insert and locate through one shared compare
//   unit. s_axis_tready_o is high only while the sequencer is idle, so a
//   new request is taken only once the previous result has left the sequencer.
//   Results pass through an output register, so a new request is taken while
//   the previous result waits; if m_axis_tready_i stays low, the next result
//   holds in the sequencer and no further request is taken.
//   Reset clears the entry count to zero and empties the output register;
//   the entry memory needs no clearing since only entries below the count
//   are ever read.
module bounded_array_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // value[31:0], position[36:32], zero[39:37]
  input  logic [2:0]  s_axis_tuser_i,  // op[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // found_index[3:0], read_value[35:4],
                                       // entry_count[40:36], zero[47:41]
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  bale_pkg::req_t req;
  bale_pkg::res_t res, out_q, out_d;
  logic           out_valid_q, out_valid_d;
  logic           idle, done, res_ready, start;

  logic                              mem_we, mem_re;
  logic [AW-1:0]                     mem_waddr, mem_raddr;
  logic signed [bale_pkg::DataW-1:0] mem_wdata, mem_rdata;

  always_comb begin
    req.op       = s_axis_tuser_i;
    req.value    = s_axis_tdata_i[31:0];
    req.position = s_axis_tdata_i[36:32];
  end

  assign s_axis_tready_o = idle;
  assign start           = s_axis_tvalid_i & idle;

  // Output register is free when empty or being drained this cycle.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (done && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {7'b0, out_q.entry_count, out_q.read_value, out_q.found_index};

  bale_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .AW       (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .idle_o      (idle),
    .done_o      (done),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bale_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
